/* design/uag_pkg.sv */
// ----------------------------------------------------------------------------
// uag_pkg
// Shared types, constants and character classes for the URL argument guard.
// ----------------------------------------------------------------------------
`default_nettype none

package uag_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [16:0] PORT_MAX        = 17'd65535;
    localparam logic [2:0]  PORT_DIGITS_MAX = 3'd5;
    localparam logic [2:0]  SUFFIX_SAT      = 3'd6;
    localparam logic [1:0]  SCHEME_SAT      = 2'd2;

    // Progress of the "--" match: zero, one or two dashes, or no match.
    localparam logic [1:0] DASH_NONE   = 2'd0;
    localparam logic [1:0] DASH_DOUBLE = 2'd2;
    localparam logic [1:0] DASH_MISS   = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       arg_end;
        logic       list_end;
    } uag_in_t;

    typedef struct packed {
        logic arg_is_url;
        logic list_safe;
        logic final_verdict;
    } uag_out_t;

    // Classification of one finished argument, handed from front to back.
    typedef struct packed {
        logic is_url;
        logic is_dash_dash;
        logic list_end;
    } uag_summary_t;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_scheme_char(input logic [7:0] c);
        is_scheme_char = is_letter(c) || is_digit(c) || (c == CHAR_PLUS) ||
                         (c == CHAR_MINUS) || (c == CHAR_DOT);
    endfunction

endpackage

`default_nettype wire

/* design/uag_front.sv */
// ----------------------------------------------------------------------------
// uag_front
// Takes one argument byte per cycle while the queue is not full and classifies the argument at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module uag_front
    import uag_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire uag_in_t      item,
    input  wire logic         q_full,
    output logic              q_push,
    output uag_summary_t      q_data
);

    logic        after_colon_reg,  after_colon_next;
    logic [1:0]  scheme_len_reg,   scheme_len_next;
    logic        scheme_valid_reg, scheme_valid_next;
    logic        scheme_dot_reg,   scheme_dot_next;
    logic [2:0]  suffix_len_reg,   suffix_len_next;
    logic        suffix_dig_reg,   suffix_dig_next;
    logic [16:0] port_reg,         port_next;
    logic [1:0]  dash_reg,         dash_next;

    logic        accept;
    logic [7:0]  c;
    logic [16:0] port_x10;
    logic        host_port;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign c      = item.char_code;
    assign port_x10 = (port_reg << 3) + (port_reg << 1);

    always_comb
    begin
        after_colon_next  = after_colon_reg;
        scheme_len_next   = scheme_len_reg;
        scheme_valid_next = scheme_valid_reg;
        scheme_dot_next   = scheme_dot_reg;
        suffix_len_next   = suffix_len_reg;
        suffix_dig_next   = suffix_dig_reg;
        port_next         = port_reg;
        dash_next         = dash_reg;
        if (item.has_char)
        begin
            if ((dash_reg < DASH_DOUBLE) && (c == CHAR_MINUS))
                dash_next = dash_reg + 2'd1;
            else
                dash_next = DASH_MISS;

            if (!after_colon_reg)
            begin
                if (c == CHAR_COLON)
                    after_colon_next = 1'b1;
                else
                begin
                    if (scheme_len_reg == 2'd0)
                    begin
                        if (!is_letter(c))
                            scheme_valid_next = 1'b0;
                    end
                    else if (!is_scheme_char(c))
                        scheme_valid_next = 1'b0;
                    if (c == CHAR_DOT)
                        scheme_dot_next = 1'b1;
                    if (scheme_len_reg < SCHEME_SAT)
                        scheme_len_next = scheme_len_reg + 2'd1;
                end
            end
            else
            begin
                if (!is_digit(c))
                    suffix_dig_next = 1'b0;
                else if (suffix_len_reg < PORT_DIGITS_MAX)
                    port_next = port_x10 + {13'd0, c[3:0]};
                if (suffix_len_reg < SUFFIX_SAT)
                    suffix_len_next = suffix_len_reg + 3'd1;
            end
        end
    end

    // A dotted scheme followed by a plain port number is a host:port.
    assign host_port = scheme_dot_next && (suffix_len_next != 3'd0) &&
                       (suffix_len_next <= PORT_DIGITS_MAX) && suffix_dig_next &&
                       (port_next != 17'd0) && (port_next <= PORT_MAX);

    always_comb
    begin
        q_push              = accept && item.arg_end;
        q_data.is_url       = after_colon_next && (scheme_len_next == SCHEME_SAT) &&
                              scheme_valid_next && !host_port;
        q_data.is_dash_dash = (dash_next == DASH_DOUBLE);
        q_data.list_end     = item.list_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_colon_reg  <= 1'b0;
            scheme_len_reg   <= 2'd0;
            scheme_valid_reg <= 1'b1;
            scheme_dot_reg   <= 1'b0;
            suffix_len_reg   <= 3'd0;
            suffix_dig_reg   <= 1'b1;
            port_reg         <= 17'd0;
            dash_reg         <= DASH_NONE;
        end
        else if (accept)
        begin
            if (item.arg_end)
            begin
                after_colon_reg  <= 1'b0;
                scheme_len_reg   <= 2'd0;
                scheme_valid_reg <= 1'b1;
                scheme_dot_reg   <= 1'b0;
                suffix_len_reg   <= 3'd0;
                suffix_dig_reg   <= 1'b1;
                port_reg         <= 17'd0;
                dash_reg         <= DASH_NONE;
            end
            else
            begin
                after_colon_reg  <= after_colon_next;
                scheme_len_reg   <= scheme_len_next;
                scheme_valid_reg <= scheme_valid_next;
                scheme_dot_reg   <= scheme_dot_next;
                suffix_len_reg   <= suffix_len_next;
                suffix_dig_reg   <= suffix_dig_next;
                port_reg         <= port_next;
                dash_reg         <= dash_next;
            end
        end
    end

endmodule

`default_nettype wire

/* design/uag_queue.sv */
// ----------------------------------------------------------------------------
// uag_queue
// Short register queue of argument summaries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module uag_queue
    import uag_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire uag_summary_t  wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output uag_summary_t       rd_data,
    output logic               empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    uag_summary_t   mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

/* design/uag_back.sv */
// ----------------------------------------------------------------------------
// uag_back
// Keeps the running list verdict and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module uag_back
    import uag_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire uag_summary_t  q_data,
    output logic               q_pop,
    output logic               empty,
    input  wire logic          pop,
    output uag_out_t           result
);

    logic     url_seen_reg,     url_seen_next;
    logic     list_blocked_reg, list_blocked_next;
    logic     list_stopped_reg, list_stopped_next;
    logic     out_valid_reg;
    uag_out_t out_reg, out_next;

    assign q_pop  = !q_empty && (!out_valid_reg || pop);
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        url_seen_next     = url_seen_reg;
        list_blocked_next = list_blocked_reg;
        list_stopped_next = list_stopped_reg;
        // Once "--" is seen the verdict no longer moves for this list.
        if (!list_stopped_reg)
        begin
            if (q_data.is_dash_dash)
                list_stopped_next = 1'b1;
            else if (url_seen_reg)
                list_blocked_next = 1'b1;
            else if (q_data.is_url)
                url_seen_next = 1'b1;
        end
        out_next.arg_is_url    = q_data.is_url;
        out_next.list_safe     = !list_blocked_next;
        out_next.final_verdict = q_data.list_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_seen_reg     <= 1'b0;
            list_blocked_reg <= 1'b0;
            list_stopped_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_data.list_end)
                begin
                    url_seen_reg     <= 1'b0;
                    list_blocked_reg <= 1'b0;
                    list_stopped_reg <= 1'b0;
                end
                else
                begin
                    url_seen_reg     <= url_seen_next;
                    list_blocked_reg <= list_blocked_next;
                    list_stopped_reg <= list_stopped_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

/* design/url_argument_guard.sv */
// ----------------------------------------------------------------------------
// url_argument_guard
// Streaming guard that flags URL arguments and blocks arguments after them.
// ----------------------------------------------------------------------------
// The block takes one argument byte per clock cycle while full is low, and gives
// one result for every item that ends an argument. The front classifier
// updates its per-argument flags and the port accumulator for every byte;
// once the closing item is taken, the summary of an argument is written into
// the queue and from there moved into the result output register. A
// queue of QUEUE_DEPTH argument summaries sits between the classifier and
// the list verdict stage, and one output register holds the oldest result,
// so the input side keeps running while results wait to be popped; full
// rises only when that queue and the output register are both occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module url_argument_guard
    import uag_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire uag_in_t  item,
    output logic          empty,
    input  wire logic     pop,
    output uag_out_t      result
);

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    uag_summary_t q_wr_data;
    uag_summary_t q_rd_data;

    uag_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    uag_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    uag_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n) q_push |-> !q_full
    ) else $error("summary written into a full queue");

    a_no_pop_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty
    ) else $error("summary read from an empty queue");

    a_result_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push && !full && item.arg_end && q_empty && empty) |=> ##1 !empty
    ) else $error("result missing two cycles after an idle argument end");

endmodule

`default_nettype wire

/* tb/tb_url_argument_guard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_url_argument_guard
// Streams argument lists byte by byte through the URL argument guard and
// checks every per-argument verdict against an in-bench prediction of the
// URL classification, the host:port exception and the list blocking rules.
// ----------------------------------------------------------------------------

module tb_url_argument_guard;

    import uag_pkg::*;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam int         LIMIT_CYCLES = 200000;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         DRAIN_CYCLES = 10;

    typedef logic [7:0] byte_q_t[$];

    // Prediction of the guard and the store of verdicts still to arrive.
    class guard_scoreboard;
        bit        after_colon;
        bit [1:0]  scheme_len;
        bit        scheme_ok;
        bit        scheme_dot;
        bit [2:0]  suffix_len;
        bit        suffix_numeric;
        bit [16:0] port_acc;
        bit [1:0]  dash_state;
        bit        url_seen;
        bit        blocked;
        bit        frozen;
        uag_out_t  verdict_q[$];
        int        mismatches;
        int        verdicts_checked;

        function new();
            clear_argument();
            clear_list();
            mismatches       = 0;
            verdicts_checked = 0;
        endfunction

        function void clear_argument();
            after_colon    = 1'b0;
            scheme_len     = 2'd0;
            scheme_ok      = 1'b1;
            scheme_dot     = 1'b0;
            suffix_len     = 3'd0;
            suffix_numeric = 1'b1;
            port_acc       = 17'd0;
            dash_state     = DASH_NONE;
        endfunction

        function void clear_list();
            url_seen = 1'b0;
            blocked  = 1'b0;
            frozen   = 1'b0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void note_request(uag_in_t req);
            logic [7:0] c;
            bit         url;
            uag_out_t   verdict;
            c = req.char_code;
            if (req.has_char)
            begin
                if (dash_state < DASH_DOUBLE && c == CHAR_MINUS)
                    dash_state = dash_state + 2'd1;
                else
                    dash_state = DASH_MISS;
                if (!after_colon)
                begin
                    if (c == CHAR_COLON)
                        after_colon = 1'b1;
                    else
                    begin
                        if (scheme_len == 2'd0)
                        begin
                            if (!is_alpha(c))
                                scheme_ok = 1'b0;
                        end
                        else if (!(is_alpha(c) || is_num(c) || c == CHAR_PLUS ||
                                   c == CHAR_MINUS || c == CHAR_DOT))
                            scheme_ok = 1'b0;
                        if (c == CHAR_DOT)
                            scheme_dot = 1'b1;
                        if (scheme_len < SCHEME_SAT)
                            scheme_len = scheme_len + 2'd1;
                    end
                end
                else
                begin
                    if (!is_num(c))
                        suffix_numeric = 1'b0;
                    else if (suffix_len < PORT_DIGITS_MAX)
                        port_acc = port_acc * 17'd10 + {9'd0, c - CHAR_ZERO};
                    if (suffix_len < SUFFIX_SAT)
                        suffix_len = suffix_len + 3'd1;
                end
            end
            if (!req.arg_end)
                return;

            url = after_colon && scheme_len >= SCHEME_SAT && scheme_ok;
            // A dotted scheme followed by a short numeric port is a host:port.
            if (url && scheme_dot && suffix_numeric && suffix_len != 3'd0 &&
                suffix_len <= PORT_DIGITS_MAX && port_acc != 17'd0 && port_acc <= PORT_MAX)
                url = 1'b0;
            if (!frozen)
            begin
                if (dash_state == DASH_DOUBLE)
                    frozen = 1'b1;
                else if (url_seen)
                    blocked = 1'b1;
                else if (url)
                    url_seen = 1'b1;
            end
            verdict.arg_is_url    = url;
            verdict.list_safe     = !blocked;
            verdict.final_verdict = req.list_end;
            verdict_q.push_back(verdict);
            clear_argument();
            if (req.list_end)
                clear_list();
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_verdict(uag_out_t got);
            uag_out_t want;
            verdicts_checked++;
            if (verdict_q.size() == 0)
            begin
                report($sformatf("verdict %0d (%b) arrived with none expected",
                                 verdicts_checked, got));
                return;
            end
            want = verdict_q.pop_front();
            if (got.arg_is_url !== want.arg_is_url)
                report($sformatf("verdict %0d arg_is_url %b, expected %b",
                                 verdicts_checked, got.arg_is_url, want.arg_is_url));
            if (got.list_safe !== want.list_safe)
                report($sformatf("verdict %0d list_safe %b, expected %b",
                                 verdicts_checked, got.list_safe, want.list_safe));
            if (got.final_verdict !== want.final_verdict)
                report($sformatf("verdict %0d final_verdict %b, expected %b",
                                 verdicts_checked, got.final_verdict, want.final_verdict));
        endtask
    endclass

    logic     clk;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     pop = 1'b0;
    logic     full;
    logic     empty;
    uag_in_t  item = '0;
    uag_out_t result;

    guard_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  requests_sent = 0;
    int  cycle_count = 0;
    bit  stall_toggle = 1'b0;

    string port_texts[9] = '{"65535", "65536", "1", "0", "00000", "99999",
                             "80", "443", "123456"};

    url_argument_guard dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic byte_q_t to_bytes(string s);
        byte_q_t text;
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        return text;
    endfunction

    function automatic logic [7:0] random_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_scheme_char();
        case ($urandom_range(0, 5))
            0, 1:    return random_letter();
            2:       return CHAR_ZERO + 8'($urandom_range(0, 9));
            3:       return CHAR_PLUS;
            4:       return CHAR_MINUS;
            default: return CHAR_DOT;
        endcase
    endfunction

    // Half scheme:suffix shapes, with dashes, empty, arbitrary bytes and letters mixed in.
    function automatic byte_q_t random_argument();
        byte_q_t text;
        int      n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    if (i == 0 && $urandom_range(0, 3) != 0)
                        text.push_back(random_letter());
                    else if ($urandom_range(0, 11) == 0)
                        text.push_back(8'($urandom_range(0, 255)));
                    else
                        text.push_back(random_scheme_char());
                end
                if (n >= 2 && $urandom_range(0, 2) == 0)
                    text[n - 1] = CHAR_DOT;
                if ($urandom_range(0, 6) != 0)
                    text.push_back(CHAR_COLON);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        n = $urandom_range(0, 7);
                        for (int i = 0; i < n; i++)
                            text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    end
                    1:
                        text = {text, to_bytes(port_texts[$urandom_range(0, 8)])};
                    2:
                    begin
                        n = $urandom_range(1, 4);
                        for (int i = 0; i < n; i++)
                            text.push_back(8'($urandom_range(0, 255)));
                    end
                    default:
                    begin
                        n = $urandom_range(0, 3);
                        for (int i = 0; i < n; i++)
                            text.push_back(random_letter());
                    end
                endcase
            end
            5:
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: text = to_bytes("--");
                    3:       text = to_bytes("-");
                    4:       text = to_bytes("---");
                    default:
                    begin
                        text = to_bytes("--");
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            6:
                text.delete();
            7, 8:
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    text.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    text.push_back(random_letter());
            end
        endcase
        return text;
    endfunction

    task automatic send_request(input uag_in_t req, input bit counted);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (full);
        sb.note_request(req);
        if (counted)
            requests_sent++;
    endtask

    // An empty text becomes a single item with no byte that closes the argument.
    task automatic send_argument(input byte_q_t text, input bit last_in_list);
        uag_in_t req;
        if (text.size() == 0)
        begin
            req.char_code = 8'($urandom_range(0, 255));
            req.has_char  = 1'b0;
            req.arg_end   = 1'b1;
            req.list_end  = last_in_list;
            send_request(req, 1'b1);
        end
        else
        begin
            foreach (text[i])
            begin
                req.char_code = text[i];
                req.has_char  = 1'b1;
                req.arg_end   = (i == text.size() - 1);
                req.list_end  = req.arg_end ? last_in_list : ($urandom_range(0, 15) == 0);
                send_request(req, 1'b1);
            end
        end
    endtask

    task automatic random_list();
        uag_in_t stray;
        int      n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                stray.char_code = 8'($urandom_range(0, 255));
                stray.has_char  = 1'b0;
                stray.arg_end   = 1'b0;
                stray.list_end  = 1'($urandom_range(0, 1));
                send_request(stray, 1'b0);
            end
            send_argument(random_argument(), i == n - 1);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Result side: random pops, plus a long hold-off whenever the sender asks.
    initial
    begin
        bit seen_toggle;
        int hold_left;
        seen_toggle = 1'b0;
        hold_left   = 0;
        @(posedge rst_n);
        forever
        begin
            if (stall_toggle != seen_toggle)
            begin
                seen_toggle = stall_toggle;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(posedge clk);
            if (pop && !empty)
                sb.check_verdict(result);
        end
    end

    initial
    begin
        uag_in_t stray;
        byte_q_t text;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 53;

        // First list: host:port exception, a stray item, a URL, then a freeze.
        send_argument(to_bytes("a.:1"), 1'b0);
        stray.char_code = 8'hFF;
        stray.has_char  = 1'b0;
        stray.arg_end   = 1'b0;
        stray.list_end  = 1'b1;
        send_request(stray, 1'b0);
        send_argument(to_bytes("ab:"), 1'b0);
        send_argument(to_bytes("--"), 1'b0);
        text.delete();
        text.push_back(8'h00);
        text.push_back(8'hFF);
        send_argument(text, 1'b1);
        // Second list: URL with an over-long port, then blocked arguments.
        send_argument(to_bytes("a.:000001"), 1'b0);
        text.delete();
        send_argument(text, 1'b0);
        send_argument(to_bytes("q"), 1'b1);

        while (requests_sent < 400)
            random_list();

        // Hold the result side off and keep offering until the block stalls.
        drain();
        stall_toggle <= ~stall_toggle;
        for (int i = 0; i < 30; i++)
        begin
            text.delete();
            text.push_back(random_letter());
            send_argument(text, i == 29);
        end

        send_idle_pct = 53;
        recv_idle_pct = 7;
        while (requests_sent < 780)
            random_list();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (requests_sent < 1150)
            random_list();

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
